// ===== sv/rau_pkg.sv =====
// Package for the rational arithmetic unit: widths, operation codes, status and
// compare codes, sequencer states and divider request/response types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;
    localparam int WIDTH = 32;
    localparam int PW = 2 * WIDTH;

    typedef enum logic [2:0] {
        FN_ADD = 3'd0,
        FN_SUB = 3'd1,
        FN_MUL = 3'd2,
        FN_DIV = 3'd3,
        FN_CMP = 3'd4
    } t_func;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_ZDEN = 2'd2;

    localparam logic [1:0] CMP_LT = 2'd0;
    localparam logic [1:0] CMP_EQ = 2'd1;
    localparam logic [1:0] CMP_GT = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_COMB,
        S_DIV1,
        S_GCD,
        S_DIV2,
        S_DIV3,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       start;
        logic [PW:0] dividend;
        logic [PW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic          busy;
        logic          done;
        logic [PW:0]   quo;
        logic [PW-1:0] rem;
    } t_div_rsp;
endpackage
`default_nettype wire

// ===== sv/rational_arith_unit.sv =====
// Top level of the rational arithmetic unit: sequencer, shared multiplier,
// shared serial divider (rau_div). Depends on rau_pkg and rau_div.
`timescale 1ns / 1ps
`default_nettype none
// One request at a time. Errors and compares set their result in S_DIV1,
// without the divider. Arithmetic takes three multiplies, one division for the
// remainder, a Euclid GCD of one division a step, and two more divisions to
// reduce. i_stall holds the result in the output register.
module rational_arith_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_func,
    input  wire logic [31:0] i_a_num,
    input  wire logic [31:0] i_a_den,
    input  wire logic        i_a_neg,
    input  wire logic [31:0] i_b_num,
    input  wire logic [31:0] i_b_den,
    input  wire logic        i_b_neg,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_res_num,
    output logic [31:0]      o_res_den,
    output logic             o_res_neg,
    output logic [1:0]       o_cmp,
    output logic [1:0]       o_status
);
    localparam int W  = rau_pkg::WIDTH;
    localparam int PW = rau_pkg::PW;

    rau_pkg::t_state r_st, n_st;
    logic [2:0]   r_fn, n_fn;
    logic [W-1:0] r_an, r_ad, r_bn, r_bd, n_an, n_ad, n_bn, n_bd;
    logic         r_as, r_bs, n_as, n_bs;
    logic [PW-1:0] r_l, r_r, r_d, n_l, n_r, n_d;
    logic [PW:0]  r_n, n_n;
    logic         r_neg, n_neg;
    logic [PW-1:0] r_x, n_x, r_rd, n_rd;
    logic [W-1:0] r_ma, r_mb, n_ma, n_mb;
    logic [PW-1:0] r_p;
    logic [31:0]  r_on, r_od, n_on, n_od;
    logic         r_oneg, n_oneg, r_ov, n_ov;
    logic [1:0]   r_oc, r_os, n_oc, n_os;
    rau_pkg::t_div_req w_req;
    rau_pkg::t_div_rsp w_rsp;
    logic         w_acc, w_bs2, w_skip;
    logic [PW:0]  w_sum;

    rau_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    assign w_acc   = i_valid && !o_stall;
    assign o_stall = (r_st != rau_pkg::S_IDLE) || (r_ov && i_stall);
    assign w_skip  = r_fn > rau_pkg::FN_CMP || r_ad == '0 || r_bd == '0
                     || (r_fn == rau_pkg::FN_DIV && r_bn == '0)
                     || r_fn == rau_pkg::FN_CMP;

    always_ff @(posedge i_clk) begin
        r_p <= r_ma * r_mb;
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            rau_pkg::S_IDLE: if (w_acc) n_st = rau_pkg::S_MUL1;
            rau_pkg::S_MUL1: n_st = rau_pkg::S_MUL2;
            rau_pkg::S_MUL2: n_st = rau_pkg::S_MUL3;
            rau_pkg::S_MUL3: n_st = rau_pkg::S_COMB;
            rau_pkg::S_COMB: n_st = rau_pkg::S_DIV1;
            rau_pkg::S_DIV1: if (w_skip) n_st = rau_pkg::S_DONE;
                             else if (w_rsp.done) n_st = rau_pkg::S_GCD;
            rau_pkg::S_GCD:  if (!w_rsp.busy && r_x == '0) n_st = rau_pkg::S_DIV2;
            rau_pkg::S_DIV2: if (w_rsp.done) n_st = rau_pkg::S_DIV3;
            rau_pkg::S_DIV3: if (w_rsp.done) n_st = rau_pkg::S_DONE;
            rau_pkg::S_DONE: if (!(r_ov && i_stall)) n_st = rau_pkg::S_IDLE;
            default:         n_st = rau_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_fn = r_fn; n_an = r_an; n_ad = r_ad; n_bn = r_bn; n_bd = r_bd;
        n_as = r_as; n_bs = r_bs; n_l = r_l; n_r = r_r; n_d = r_d; n_n = r_n;
        n_neg = r_neg; n_x = r_x; n_rd = r_rd; n_ma = r_ma; n_mb = r_mb;
        n_on = r_on; n_od = r_od; n_oneg = r_oneg; n_oc = r_oc; n_os = r_os;
        n_ov = r_ov && i_stall;
        w_req = '0;
        w_bs2 = (r_fn == rau_pkg::FN_SUB) ? (r_bn != '0 && !r_bs) : r_bs;
        w_sum = {1'b0, r_l} + {1'b0, r_r};
        unique case (r_st)
            rau_pkg::S_IDLE: if (w_acc) begin
                n_fn = i_func; n_an = i_a_num[W-1:0]; n_ad = i_a_den[W-1:0];
                n_bn = i_b_num[W-1:0]; n_bd = i_b_den[W-1:0];
                n_as = i_a_neg && i_a_num[W-1:0] != '0;
                n_bs = i_b_neg && i_b_num[W-1:0] != '0;
                n_ma = i_a_num[W-1:0];
                n_mb = (i_func == rau_pkg::FN_MUL) ? i_b_num[W-1:0] : i_b_den[W-1:0];
            end
            rau_pkg::S_MUL1: begin
                n_ma = r_ad;
                n_mb = (r_fn == rau_pkg::FN_MUL) ? r_bd : r_bn;
            end
            rau_pkg::S_MUL2: begin
                n_l = r_p;
                n_ma = r_ad; n_mb = r_bd;
            end
            rau_pkg::S_MUL3: begin
                n_r = r_p;
            end
            rau_pkg::S_COMB: begin
                n_d = r_p;
                if (r_fn == rau_pkg::FN_MUL) begin
                    n_n = {1'b0, r_l}; n_d = r_p; n_neg = r_as != r_bs;
                end else if (r_fn == rau_pkg::FN_DIV) begin
                    n_n = {1'b0, r_l}; n_d = r_r; n_neg = r_as != r_bs;
                end else if (r_as == w_bs2) begin
                    n_n = w_sum; n_neg = r_as;
                end else if (r_l >= r_r) begin
                    n_n = {1'b0, r_l - r_r}; n_neg = r_as;
                end else begin
                    n_n = {1'b0, r_r - r_l}; n_neg = w_bs2;
                end
                w_req.start = !w_skip;
                w_req.dividend = (r_fn == rau_pkg::FN_MUL || r_fn == rau_pkg::FN_DIV)
                                 ? {1'b0, r_l} : n_n;
                w_req.divisor = (r_fn == rau_pkg::FN_DIV) ? r_r : r_p;
            end
            rau_pkg::S_DIV1: begin
                n_on = '0; n_od = '0; n_oneg = 1'b0; n_oc = rau_pkg::CMP_LT;
                n_os = rau_pkg::ST_OK;
                if (r_fn > rau_pkg::FN_CMP) begin
                    n_ov = 1'b1;
                end else if (r_ad == '0 || r_bd == '0
                             || (r_fn == rau_pkg::FN_DIV && r_bn == '0)) begin
                    n_os = rau_pkg::ST_ZDEN; n_ov = 1'b1;
                end else if (r_fn == rau_pkg::FN_CMP) begin
                    if (r_as != r_bs) n_oc = r_as ? rau_pkg::CMP_LT : rau_pkg::CMP_GT;
                    else if (r_l == r_r) n_oc = rau_pkg::CMP_EQ;
                    else if ((r_l < r_r) != r_as) n_oc = rau_pkg::CMP_LT;
                    else n_oc = rau_pkg::CMP_GT;
                    n_ov = 1'b1;
                end else if (w_rsp.done) begin
                    n_rd = r_d; n_x = w_rsp.rem;
                end
            end
            rau_pkg::S_GCD: if (!w_rsp.busy) begin
                if (w_rsp.done) begin
                    n_rd = r_x; n_x = w_rsp.rem;
                end else if (r_x != '0) begin
                    w_req.start = 1'b1;
                    w_req.dividend = {1'b0, r_rd};
                    w_req.divisor = r_x;
                end else begin
                    w_req.start = 1'b1;
                    w_req.dividend = r_n;
                    w_req.divisor = r_rd;
                end
            end
            rau_pkg::S_DIV2: if (w_rsp.done) begin
                n_n = w_rsp.quo;
                w_req.start = 1'b1;
                w_req.dividend = {1'b0, r_d};
                w_req.divisor = r_rd;
            end
            rau_pkg::S_DIV3: if (w_rsp.done) begin
                n_ov = 1'b1;
                if (r_n[PW:W] != '0 || w_rsp.quo[PW:W] != '0) begin
                    n_os = rau_pkg::ST_OVF;
                end else begin
                    n_on = 32'(r_n[W-1:0]); n_od = 32'(w_rsp.quo[W-1:0]);
                    n_oneg = r_neg && r_n != '0;
                end
            end
            rau_pkg::S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_fn <= n_fn; r_an <= n_an; r_ad <= n_ad; r_bn <= n_bn; r_bd <= n_bd;
        r_as <= n_as; r_bs <= n_bs; r_l <= n_l; r_r <= n_r; r_d <= n_d;
        r_n <= n_n; r_neg <= n_neg; r_x <= n_x; r_rd <= n_rd;
        r_ma <= n_ma; r_mb <= n_mb;
        r_on <= n_on; r_od <= n_od; r_oneg <= n_oneg; r_oc <= n_oc; r_os <= n_os;
        if (!i_rst_n) begin
            r_st <= rau_pkg::S_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ov <= n_ov;
        end
    end

    assign o_valid   = r_ov;
    assign o_res_num = r_on;
    assign o_res_den = r_od;
    assign o_res_neg = r_oneg;
    assign o_cmp     = r_oc;
    assign o_status  = r_os;

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != rau_pkg::S_IDLE) |-> !w_acc) else $error("request taken while busy");
    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> !w_rsp.busy) else $error("divider restarted while busy");
    a_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res_num == '0) |-> !o_res_neg) else $error("negative zero");
`endif
endmodule
`default_nettype wire

// ===== sv/rau_div.sv =====
// Restoring divider, one quotient bit a cycle, 65-bit dividend by 64-bit divisor.
// Depends on rau_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rau_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rau_pkg::t_div_req i_req,
    output rau_pkg::t_div_rsp      o_rsp
);
    logic [rau_pkg::PW:0]   r_quo, n_quo;
    logic [rau_pkg::PW-1:0] r_rem, n_rem;
    logic [rau_pkg::PW-1:0] r_dsr, n_dsr;
    logic [6:0]             r_cnt, n_cnt;
    logic                   r_busy, n_busy, r_done, n_done;
    logic [rau_pkg::PW:0]   w_sh;
    logic                   w_take;

    always_comb begin
        w_sh   = {r_rem, r_quo[rau_pkg::PW]};
        w_take = w_sh >= {1'b0, r_dsr};
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_dsr  = i_req.divisor;
            n_cnt  = 7'(rau_pkg::PW + 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = w_take ? rau_pkg::PW'(w_sh - {1'b0, r_dsr}) : w_sh[rau_pkg::PW-1:0];
            n_quo = {r_quo[rau_pkg::PW-1:0], w_take};
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;
endmodule
`default_nettype wire
